// ===== src/bmhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhpq_pkg
// shared constants for the binary max-heap priority queue
// ----------------------------------------------------------------------------
package bmhpq_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int FIELD_W       = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

endpackage

// ===== src/bmhpq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhpq_ram
// heap storage: one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module bmhpq_ram
    import bmhpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [KEY_WIDTH-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr_a,
    input  logic [AW-1:0]        rd_addr_b,
    output logic [KEY_WIDTH-1:0] rd_data_a,
    output logic [KEY_WIDTH-1:0] rd_data_b
);

    logic [KEY_WIDTH-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== src/binary_max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// push sifts up and pop sifts down, walking at most ceil(log2(CAPACITY)) tree
// levels; one heap memory read per tree level sets the pace
// one item at a time; a finished result waits in the output register
// reset clears the state, the count and the output valid; the heap memory is not cleared
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue
    import bmhpq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int CW       = $clog2(CAPACITY + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      op,
    input  logic signed [FIELD_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [FIELD_W-1:0] popped_value,
    output logic                      was_empty,
    output logic                      was_full,
    output logic signed [FIELD_W-1:0] top_value,
    output logic                      top_valid,
    output logic [CW-1:0]             fill_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = AW + 2;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_UP_CMP   = 3'd1;
    localparam logic [2:0] S_UP_FIN   = 3'd2;
    localparam logic [2:0] S_POP_LAST = 3'd3;
    localparam logic [2:0] S_DN_CMP   = 3'd4;
    localparam logic [2:0] S_DN_FIN   = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [KEY_WIDTH-1:0] top_reg, top_next;
    logic [KEY_WIDTH-1:0] popped_reg, popped_next;
    logic                 empty_reg, empty_next;
    logic                 full_reg, full_next;

    logic                 out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]   out_popped_reg;
    logic                 out_empty_reg;
    logic                 out_full_reg;
    logic [FIELD_W-1:0]   out_top_reg;
    logic                 out_top_valid_reg;
    logic [CW-1:0]        out_count_reg;
    logic                 out_load;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [KEY_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]        rd_addr_a, rd_addr_b;
    logic [KEY_WIDTH-1:0] rd_data_a, rd_data_b;

    logic                 in_accept;
    logic [KEY_WIDTH-1:0] in_key;
    logic [AW-1:0]        parent_idx;
    logic [AW-1:0]        up_parent_idx;
    logic [IW-1:0]        left_w, right_w;
    logic                 right_ok;
    logic                 pick_right;
    logic [KEY_WIDTH-1:0] pick_val;
    logic [AW-1:0]        pick_idx;
    logic [IW-1:0]        pick_left_w;
    logic [IW-1:0]        count_w;

    bmhpq_ram #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_key    = KEY_WIDTH'({32'd0, value});

    // index arithmetic for both sift directions
    assign parent_idx    = (pos_reg - AW'(1)) >> 1;
    assign up_parent_idx = (parent_idx - AW'(1)) >> 1;
    assign count_w       = IW'(count_reg);
    assign left_w        = IW'({pos_reg, 1'b1});
    assign right_w       = left_w + IW'(1);
    assign right_ok      = (right_w < count_w);
    assign pick_right    = right_ok && ($signed(rd_data_b) > $signed(rd_data_a));
    assign pick_val      = pick_right ? rd_data_b : rd_data_a;
    assign pick_idx      = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
    assign pick_left_w   = IW'({pick_idx, 1'b1});

    assign out_load = (state_reg == S_RESP) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        top_next    = top_reg;
        popped_next = popped_reg;
        empty_next  = empty_reg;
        full_next   = full_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = key_reg;
        rd_addr_a   = parent_idx;
        rd_addr_b   = right_w[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    popped_next = '0;
                    empty_next  = 1'b0;
                    full_next   = 1'b0;
                    if (op == OP_PUSH)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            full_next  = 1'b1;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            pos_next   = count_reg[AW-1:0];
                            key_next   = in_key;
                            if (count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = in_key;
                                top_next   = in_key;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                rd_addr_a  = (count_reg[AW-1:0] - AW'(1)) >> 1;
                                state_next = S_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            empty_next = 1'b1;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            popped_next = top_reg;
                            count_next  = count_reg - CW'(1);
                            if (count_reg == CW'(1))
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                // fetch the last element to refill the root
                                rd_addr_a  = AW'(count_reg - CW'(1));
                                state_next = S_POP_LAST;
                            end
                        end
                    end
                end
            end

            S_UP_CMP:
            begin
                if ($signed(key_reg) > $signed(rd_data_a))
                begin
                    // parent moves down into the hole
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg;
                    mem_wdata = rd_data_a;
                    pos_next  = parent_idx;
                    if (parent_idx == '0)
                    begin
                        state_next = S_UP_FIN;
                    end
                    else
                    begin
                        rd_addr_a = up_parent_idx;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg;
                    mem_wdata  = key_reg;
                    state_next = S_RESP;
                end
            end

            S_UP_FIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = key_reg;
                top_next   = key_reg;
                state_next = S_RESP;
            end

            S_POP_LAST:
            begin
                key_next = rd_data_a;
                pos_next = '0;
                if (count_reg == CW'(1))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = rd_data_a;
                    top_next   = rd_data_a;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_addr_a  = AW'(1);
                    rd_addr_b  = AW'(2 % CAPACITY);
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                if ($signed(pick_val) > $signed(key_reg))
                begin
                    // larger child moves up into the hole
                    mem_wdata = pick_val;
                    if (pos_reg == '0)
                    begin
                        top_next = pick_val;
                    end
                    pos_next  = pick_idx;
                    rd_addr_a = pick_left_w[AW-1:0];
                    rd_addr_b = AW'(pick_left_w + IW'(1));
                    if (pick_left_w >= count_w)
                    begin
                        state_next = S_DN_FIN;
                    end
                end
                else
                begin
                    mem_wdata = key_reg;
                    if (pos_reg == '0)
                    begin
                        top_next = key_reg;
                    end
                    state_next = S_RESP;
                end
            end

            S_DN_FIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = key_reg;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        top_reg    <= top_next;
        popped_reg <= popped_next;
        empty_reg  <= empty_next;
        full_reg   <= full_next;
        if (out_load)
        begin
            out_popped_reg    <= FIELD_W'(64'(popped_reg));
            out_empty_reg     <= empty_reg;
            out_full_reg      <= full_reg;
            out_top_reg       <= (count_reg != '0) ? FIELD_W'(64'(top_reg)) : '0;
            out_top_valid_reg <= (count_reg != '0);
            out_count_reg     <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_popped_reg;
    assign was_empty    = out_empty_reg;
    assign was_full     = out_full_reg;
    assign top_value    = out_top_reg;
    assign top_valid    = out_top_valid_reg;
    assign fill_count   = out_count_reg;

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_empty && was_full))
        else $error("empty and full flags both set");

    a_top_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (top_valid == (fill_count != '0)))
        else $error("top valid disagrees with fill count");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted item did not start work");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the binary max-heap priority queue: a directed
// table (empty pop, key extremes, equal keys) followed by random push/pop
// runs that fill the heap past capacity and drain it past empty, each result
// compared field by field with the table's expected row or a behavioural heap kept in the bench
// ----------------------------------------------------------------------------
module tb_top
    import bmhpq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W      = $clog2(CAPACITY_DEF + 1);
    localparam int DIR_ROWS   = 26;
    localparam int RAND_ITEMS = 1124;
    localparam int LONG_HOLD  = 200;
    localparam int TAIL_WAIT  = 40;
    localparam int MAX_PRINTS = 50;

    localparam logic signed [FIELD_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_W-1:0] KEY_MIN = 32'sh8000_0000;

    // op mixes for the random runs, push weight out of 16
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_PUSHY} op_mix_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] popped;
        logic                      empty;
        logic                      full;
        logic signed [FIELD_W-1:0] top;
        logic                      top_ok;
        logic [CNT_W-1:0]          count;
    } heap_result_t;

    typedef struct packed {
        logic                      typed;
        logic                      op;
        logic signed [FIELD_W-1:0] value;
        heap_result_t              want;
    } stim_row_t;

    localparam heap_result_t NO_RESULT = '0;

    localparam stim_row_t STIM_TABLE [DIR_ROWS] = '{
        '{1'b1, OP_POP,  -32'sd1, '{32'sd0,   1'b1, 1'b0, 32'sd0,  1'b0, 7'd0}},
        '{1'b1, OP_PUSH, KEY_MAX, '{32'sd0,   1'b0, 1'b0, KEY_MAX, 1'b1, 7'd1}},
        '{1'b1, OP_PUSH, KEY_MIN, '{32'sd0,   1'b0, 1'b0, KEY_MAX, 1'b1, 7'd2}},
        '{1'b1, OP_POP,  KEY_MIN, '{KEY_MAX,  1'b0, 1'b0, KEY_MIN, 1'b1, 7'd1}},
        '{1'b1, OP_POP,  KEY_MAX, '{KEY_MIN,  1'b0, 1'b0, 32'sd0,  1'b0, 7'd0}},
        '{1'b0, OP_PUSH, 32'sd0,  NO_RESULT},
        '{1'b0, OP_PUSH, -32'sd1, NO_RESULT},
        '{1'b0, OP_PUSH, 32'sd5,  NO_RESULT},
        '{1'b0, OP_PUSH, 32'sd5,  NO_RESULT},
        '{1'b0, OP_PUSH, 32'sd5,  NO_RESULT},
        '{1'b0, OP_PUSH, 32'sd3,  NO_RESULT},
        '{1'b0, OP_PUSH, 32'sd3,  NO_RESULT},
        '{1'b0, OP_PUSH, KEY_MIN, NO_RESULT},
        '{1'b0, OP_PUSH, KEY_MAX, NO_RESULT},
        '{1'b0, OP_PUSH, 32'sd1,  NO_RESULT},
        '{1'b0, OP_POP,  -32'sd1, NO_RESULT},
        '{1'b0, OP_POP,  32'sd0,  NO_RESULT},
        '{1'b0, OP_POP,  KEY_MAX, NO_RESULT},
        '{1'b0, OP_POP,  -32'sd1, NO_RESULT},
        '{1'b0, OP_POP,  KEY_MIN, NO_RESULT},
        '{1'b0, OP_POP,  -32'sd1, NO_RESULT},
        '{1'b0, OP_POP,  32'sd0,  NO_RESULT},
        '{1'b0, OP_POP,  -32'sd1, NO_RESULT},
        '{1'b0, OP_POP,  KEY_MAX, NO_RESULT},
        '{1'b0, OP_POP,  -32'sd1, NO_RESULT},
        '{1'b1, OP_POP,  -32'sd1, '{32'sd0,   1'b1, 1'b0, 32'sd0,  1'b0, 7'd0}}
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      op        = OP_PUSH;
    logic signed [FIELD_W-1:0] value     = '0;
    logic                      out_stall = 1'b0;
    logic                      in_stall;
    logic                      out_valid;
    logic signed [FIELD_W-1:0] popped_value;
    logic                      was_empty;
    logic                      was_full;
    logic signed [FIELD_W-1:0] top_value;
    logic                      top_valid;
    logic [CNT_W-1:0]          fill_count;

    // behavioural heap, root at entry 0
    logic signed [FIELD_W-1:0] heap_keys [CAPACITY_DEF];
    int                        heap_size = 0;

    heap_result_t pending_results [$];
    int           mismatches   = 0;
    int           results_seen = 0;
    bit           idle_on      = 1'b1;
    bit           hold_request = 1'b0;

    binary_max_heap_priority_queue DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .was_empty    (was_empty),
        .was_full     (was_full),
        .top_value    (top_value),
        .top_valid    (top_valid),
        .fill_count   (fill_count)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic signed [FIELD_W-1:0] got,
                               input logic signed [FIELD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      results_seen, name, got, want));
    endtask

    // applies one push or pop to the bench heap and returns what the block should report
    task automatic heap_step(input logic step_op, input logic signed [FIELD_W-1:0] key,
                             output heap_result_t res);
        int                        pos;
        int                        left;
        int                        right;
        int                        pick;
        bit                        moving;
        logic signed [FIELD_W-1:0] tmp;
        res = '0;
        if (step_op == OP_PUSH)
        begin
            if (heap_size >= CAPACITY_DEF)
            begin
                res.full = 1'b1;
            end
            else
            begin
                pos = heap_size;
                heap_keys[pos] = key;
                heap_size++;
                // sift up while strictly greater than the parent
                while (pos > 0 && heap_keys[pos] > heap_keys[(pos - 1) / 2])
                begin
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[(pos - 1) / 2];
                    heap_keys[(pos - 1) / 2] = tmp;
                    pos = (pos - 1) / 2;
                end
            end
        end
        else if (heap_size == 0)
        begin
            res.empty = 1'b1;
        end
        else
        begin
            res.popped = heap_keys[0];
            heap_size--;
            heap_keys[0] = heap_keys[heap_size];
            pos = 0;
            moving = 1'b1;
            while (moving)
            begin
                moving = 1'b0;
                left = 2 * pos + 1;
                right = left + 1;
                if (left < heap_size)
                begin
                    // equal children: the left one wins
                    pick = left;
                    if (right < heap_size && heap_keys[right] > heap_keys[left])
                        pick = right;
                    if (heap_keys[pick] > heap_keys[pos])
                    begin
                        tmp = heap_keys[pos];
                        heap_keys[pos] = heap_keys[pick];
                        heap_keys[pick] = tmp;
                        pos = pick;
                        moving = 1'b1;
                    end
                end
            end
        end
        if (heap_size > 0)
        begin
            res.top = heap_keys[0];
            res.top_ok = 1'b1;
        end
        res.count = CNT_W'(heap_size);
    endtask

    // offers one item, holds it until taken, then records what it should produce
    task automatic offer_item(input logic item_op, input logic signed [FIELD_W-1:0] key,
                              input logic typed, input heap_result_t typed_want);
        heap_result_t res;
        in_valid <= 1'b1;
        op       <= item_op;
        value    <= key;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        heap_step(item_op, key, res);
        pending_results.push_back(typed ? typed_want : res);
    endtask

    task automatic maybe_pause();
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [FIELD_W-1:0] pick_key();
        int near;
        case ($urandom_range(0, 3))
            0:
            begin
                // narrow range so that equal keys meet in the tree
                near = $urandom_range(0, 8);
                return near - 4;
            end
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return KEY_MAX;
                    1: return KEY_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial
    begin
        int      k;
        int      seg_len;
        int      push_weight;
        bit      held;
        bit      drained;
        op_mix_t mix;
        logic    item_op;

        held = 1'b0;
        drained = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            offer_item(STIM_TABLE[r].op, STIM_TABLE[r].value, STIM_TABLE[r].typed,
                       STIM_TABLE[r].want);
            maybe_pause();
        end

        k = 0;
        // first run fills past capacity, the second drains past empty
        mix = MIX_FILL;
        while (k < RAND_ITEMS)
        begin
            if (k > 0)
                mix = op_mix_t'($urandom_range(0, 3));
            seg_len = (k < 200) ? 100 : $urandom_range(20, 90);
            if (k >= 100 && k < 200)
                mix = MIX_DRAIN;
            case (mix)
                MIX_FILL:  push_weight = 15;
                MIX_DRAIN: push_weight = 1;
                MIX_EVEN:  push_weight = 8;
                default:   push_weight = 11;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            if (!held && k >= 300)
            begin
                // long receiver hold with the sender pressing on
                held = 1'b1;
                hold_request = 1'b1;
                idle_on = 1'b0;
            end
            if (!drained && k >= 650)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            if (k >= RAND_ITEMS - 150)
                idle_on = 1'b0;
            for (int i = 0; i < seg_len && k < RAND_ITEMS; i++)
            begin
                item_op = ($urandom_range(0, 15) < push_weight) ? OP_PUSH : OP_POP;
                offer_item(item_op, pick_key(), 1'b0, NO_RESULT);
                k++;
                maybe_pause();
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // receiver stall bursts and the one long hold
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 9);
            end
            out_stall <= (stall_left > 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("popped_value", popped_value, want.popped);
                check_field("was_empty", was_empty, want.empty);
                check_field("was_full", was_full, want.full);
                check_field("top_value", top_value, want.top);
                check_field("top_valid", top_valid, want.top_ok);
                check_field("fill_count", fill_count, want.count);
            end
            results_seen++;
        end
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/bmhpq_pkg.sv
src/bmhpq_ram.sv
src/binary_max_heap_priority_queue.sv
tb/tb_top.sv
